FILE: rtl/core/assert_macros.svh
// Assertion macros used by the shield door controller RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sdmc_pkg.sv
// Types and constants of the shield door motion controller.
// Used by the control core and the top level.
package sdmc_pkg;

  localparam int unsigned ElapsedWidth = 20;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_OPENING = 2'd1;
  localparam logic [1:0] MODE_CLOSING = 2'd2;

  localparam logic [1:0] CODE_ACK_OPEN   = 2'd0;
  localparam logic [1:0] CODE_ACK_CLOSED = 2'd1;
  localparam logic [1:0] CODE_SAFETY     = 2'd2;
  localparam logic [1:0] CODE_TIMEOUT    = 2'd3;

  localparam logic ACTION_TICK    = 1'b0;
  localparam logic ACTION_COMMAND = 1'b1;

  localparam logic [ElapsedWidth-1:0] TIMEOUT_RESET = 20'd25000;
  localparam logic [ElapsedWidth-1:0] ELAPSED_MAX   = '1;

  typedef struct packed {
    logic action;
    logic want_close;
    logic reply_wanted;
    logic open_limit;
    logic closed_limit;
    logic plate_down_a;
    logic plate_down_b;
  } sdmc_item_t;

  typedef struct packed {
    logic       relay_open_on;
    logic       relay_close_on;
    logic       busy_res;
    logic       reply_valid;
    logic [1:0] reply_code;
  } sdmc_result_t;

  typedef logic [ElapsedWidth-1:0] sdmc_ticks_t;

endpackage

FILE: rtl/core/sdmc_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance; no package dependency.
interface sdmc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/sdmc_reg_stage.sv
// Registered channel stage: one item of storage between two channels.
// Uses sdmc_chan_if; the payload type follows the connected interfaces.
module sdmc_reg_stage #(
  parameter type payload_t = logic
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sdmc_chan_if.sink    up,
  sdmc_chan_if.source  dn
);

  logic     valid_q;
  logic     valid_d;
  payload_t data_q;
  logic     load;

  assign up.ready = !valid_q || dn.ready;
  assign load     = up.valid && up.ready;
  assign valid_d  = load || (valid_q && !dn.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= up.data;
    end
  end

  assign dn.valid = valid_q;
  assign dn.data  = data_q;

endmodule

FILE: rtl/core/sdmc_ctrl.sv
// Control core: motion mode, elapsed tick count, reply enable and timeout register.
// Depends on sdmc_pkg, sdmc_chan_if and assert_macros.svh.
`include "assert_macros.svh"

module sdmc_ctrl
  import sdmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sdmc_chan_if.sink   item,
  sdmc_chan_if.source res,
  sdmc_chan_if.sink   cfg
);

  logic [1:0]   mode_q, mode_d;
  sdmc_ticks_t  elapsed_q, elapsed_d;
  sdmc_ticks_t  elapsed_inc;
  sdmc_ticks_t  timeout_q;
  logic         reply_en_q, reply_en_d;
  logic         moving;
  logic         plate_ok;
  logic         have_reply;
  logic [1:0]   code;
  logic         fire;
  sdmc_item_t   it;
  sdmc_result_t result;

  assign it         = item.data;
  assign item.ready = res.ready;
  assign res.valid  = item.valid;
  assign fire       = item.valid && res.ready;
  assign cfg.ready  = 1'b1;

  assign moving      = (mode_q == MODE_OPENING) || (mode_q == MODE_CLOSING);
  assign plate_ok    = it.plate_down_a && it.plate_down_b;
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    elapsed_d  = elapsed_q;
    reply_en_d = reply_en_q;
    have_reply = 1'b0;
    code       = CODE_ACK_OPEN;
    if (it.action == ACTION_COMMAND) begin
      reply_en_d = it.reply_wanted;
      priority if (!it.want_close && it.open_limit) begin
        have_reply = 1'b1;
        code       = CODE_ACK_OPEN;
      end else if (it.want_close && it.closed_limit) begin
        have_reply = 1'b1;
        code       = CODE_ACK_CLOSED;
      end else if (!plate_ok) begin
        have_reply = 1'b1;
        code       = CODE_SAFETY;
      end else begin
        mode_d    = it.want_close ? MODE_CLOSING : MODE_OPENING;
        elapsed_d = '0;
      end
    end else if (moving) begin
      elapsed_d = elapsed_inc;
      priority if ((mode_q == MODE_OPENING) && it.open_limit) begin
        mode_d     = MODE_IDLE;
        have_reply = 1'b1;
        code       = CODE_ACK_OPEN;
      end else if ((mode_q == MODE_CLOSING) && it.closed_limit) begin
        mode_d     = MODE_IDLE;
        have_reply = 1'b1;
        code       = CODE_ACK_CLOSED;
      end else if (elapsed_inc > timeout_q) begin
        mode_d     = MODE_IDLE;
        have_reply = 1'b1;
        code       = CODE_TIMEOUT;
      end else begin
        mode_d = mode_q;
      end
    end
  end

  always_comb begin
    result.relay_open_on  = (mode_d == MODE_OPENING);
    result.relay_close_on = (mode_d == MODE_CLOSING);
    result.busy_res       = (mode_d == MODE_OPENING) || (mode_d == MODE_CLOSING);
    result.reply_valid    = have_reply && reply_en_d;
    result.reply_code     = (have_reply && reply_en_d) ? code : CODE_ACK_OPEN;
  end

  assign res.data = result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      elapsed_q  <= '0;
      reply_en_q <= 1'b0;
    end else if (fire) begin
      mode_q     <= mode_d;
      elapsed_q  <= elapsed_d;
      reply_en_q <= reply_en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      timeout_q <= cfg.data;
    end
  end

  `SDMC_ASSERT_NEXT(a_idle_tick_holds,
    fire && (it.action == ACTION_TICK) && (mode_q == MODE_IDLE),
    (mode_q == MODE_IDLE) && $stable(elapsed_q), "Tick while idle changed the state")
  `SDMC_ASSERT_SAME(a_idle_tick_silent,
    fire && (it.action == ACTION_TICK) && !moving, !result.reply_valid,
    "Reply emitted on a tick while idle")
  `SDMC_ASSERT_NEXT(a_start_clears_count,
    fire && (it.action == ACTION_COMMAND) && it.reply_wanted && !result.reply_valid,
    (elapsed_q == '0) && moving, "Silent command did not start a clean movement")
  `SDMC_ASSERT_SAME(a_one_relay,
    fire && result.busy_res, result.relay_open_on != result.relay_close_on,
    "Relay drive does not match a single direction")

endmodule

FILE: rtl/core/shield_door_motion_controller_unit.sv
// Shield door motion controller, top level.
// Item channel in, result channel out, one timeout configuration channel.
// Channels: item_i takes one tick or command item per handshake (valid and
// ready high at a rising edge of clk_i); result_o returns exactly one result
// item for every accepted item, in order; cfg_i writes the 20-bit timeout in
// ticks and is always ready.
// Path: an accepted item waits in the input register, the control core works
// out its result combinationally, and the result is held in the output
// register before result_o offers it.
// Throughput: one item per cycle while result_o.ready is high; mode and tick
// count update in one logic pass between input register and result register.
// Stall: a result waits in the output register while result_o.ready is low;
// the input register still takes one more item, after which item_i.ready
// drops until the receiver takes the waiting result.
// Reset: rst_ni is asynchronous and active low; it empties both registers,
// sets the door idle with both relays off, clears the tick count and reply
// enable, and loads a timeout of 25000 ticks.
module shield_door_motion_controller_unit
  import sdmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sdmc_chan_if.sink   item_i,
  sdmc_chan_if.source result_o,
  sdmc_chan_if.sink   cfg_i
);

  sdmc_chan_if #(.payload_t(sdmc_item_t))   item_q_if ();
  sdmc_chan_if #(.payload_t(sdmc_result_t)) res_d_if ();

  sdmc_reg_stage #(
    .payload_t (sdmc_item_t)
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .up     (item_i),
    .dn     (item_q_if)
  );

  sdmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item   (item_q_if),
    .res    (res_d_if),
    .cfg    (cfg_i)
  );

  sdmc_reg_stage #(
    .payload_t (sdmc_result_t)
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .up     (res_d_if),
    .dn     (result_o)
  );

endmodule
